/* design/bmtf_pkg.sv */
// Shared types and constants for the byte move-to-front decoder.
package bmtf_pkg;

   localparam int BYTE_W = 8;
   localparam int OP_W   = 2;
   localparam int POS_W  = 8;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
   localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

   // Request payload layout, lowest bit first: op, position, load_byte.
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef struct packed {
      logic latch;     // capture the accepted item
      logic clear;     // drop every entry back to zero
      logic rd_en;     // issue a list read
      logic rd_prev;   // read at cursor - 1 instead of cursor
      logic take;      // hold the byte read at the decode position
      logic shift_wr;  // write the read entry one place back, step cursor
      logic load_wr;   // write read entry ORed with load_byte
      logic front_wr;  // put the held byte at the front
      logic rsp_load;  // fill the result register
   } dp_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            pos_ok;
      logic            pos_zero;
      logic            cur_one;
      logic            rsp_free;
   } dp_status_type;

endpackage

/* design/byte_move_to_front_decoder_top.sv */
// Top level of the byte move-to-front decoder.
//
//   channel  dir  handshake              payload
//   req      in   req_tvalid/req_tready  req_tdata[23:0]: op, position, load_byte
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata[15:0]: symbol, front_byte
//
// One item is worked at a time; req_tready is high only when the sequencer is idle.
// Clear, an unused op, an out-of-range position or a decode at position 0 go from dispatch
// straight to done. Load reads an entry and writes it back. Decode at position p > 0 moves
// one list entry at a time through the list memory (read port, then write port back).
// Reset empties the list at once through per-entry valid bits; no clearing pass.
// A result waiting on rsp_tready holds the next item in its last state.
module byte_move_to_front_decoder_top import bmtf_pkg::*; #(
   parameter int LIST_LEN = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [1:0] op, [9:2] position, [17:10] load_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata    // [7:0] symbol, [15:8] front_byte
);

   dp_cmd_type    cmd;
   dp_status_type status;

   bmtf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bmtf_datapath #(
      .LIST_LEN (LIST_LEN)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

/* design/bmtf_ctrl.sv */
// Sequencer for clear, load and decode items of the move-to-front decoder.
module bmtf_ctrl import bmtf_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_LOAD_RD,
      ST_LOAD_WR,
      ST_TAKE_RD,
      ST_TAKE_WR,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FRONT,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.latch = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.op == OP_CLEAR) begin
               cmd.clear = 1'b1;
               state_in  = ST_DONE;
            end else if (status.op == OP_LOAD && status.pos_ok) begin
               state_in = ST_LOAD_RD;
            end else if (status.op == OP_DECODE && status.pos_ok && !status.pos_zero) begin
               state_in = ST_TAKE_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_LOAD_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD_WR;
         end
         ST_LOAD_WR: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_TAKE_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_TAKE_WR;
         end
         ST_TAKE_WR: begin
            cmd.take = 1'b1;
            state_in = ST_SHIFT_RD;
         end
         ST_SHIFT_RD: begin
            cmd.rd_en   = 1'b1;
            cmd.rd_prev = 1'b1;
            state_in    = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = status.cur_one ? ST_FRONT : ST_SHIFT_RD;
         end
         ST_FRONT: begin
            cmd.front_wr = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // hold the finished item until the result slot frees up
            if (status.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   a_shift_needs_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT_WR |-> $past(state_ff) == ST_SHIFT_RD)
      else $error("shift write without a preceding read");

   a_rsp_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> status.rsp_free)
      else $error("result loaded over a waiting result");

   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.clear, cmd.shift_wr, cmd.load_wr, cmd.front_wr, cmd.rsp_load}))
      else $error("more than one datapath action in a cycle");

endmodule

/* design/bmtf_datapath.sv */
// List memory, cursor, held byte, front register and result register.
module bmtf_datapath import bmtf_pkg::*; #(
   parameter int LIST_LEN = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  dp_cmd_type            cmd,
   output dp_status_type         status
);

   localparam int AW = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
   localparam logic [POS_W:0] LEN_LIMIT = (POS_W+1)'(LIST_LEN);

   logic [BYTE_W-1:0] mem [LIST_LEN];
   logic [LIST_LEN-1:0] valid_ff;

   logic [OP_W-1:0]   op_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [BYTE_W-1:0] load_ff;
   logic [AW-1:0]     cur_ff;
   logic [BYTE_W-1:0] taken_ff;
   logic [BYTE_W-1:0] front_ff;
   logic [BYTE_W-1:0] rdata_ff;
   logic              rvalid_ff;
   logic              rsp_valid_ff;
   logic [BYTE_W-1:0] rsp_sym_ff;
   logic [BYTE_W-1:0] rsp_front_ff;

   logic [AW-1:0]     raddr;
   logic [AW-1:0]     waddr;
   logic [BYTE_W-1:0] wdata;
   logic              we;
   logic [BYTE_W-1:0] entry;

   // entry never written since the last clear reads as zero
   assign entry = rvalid_ff ? rdata_ff : '0;
   assign raddr = cmd.rd_prev ? cur_ff - AW'(1) : cur_ff;
   assign we    = cmd.shift_wr | cmd.load_wr | cmd.front_wr;
   assign waddr = cmd.front_wr ? '0 : cur_ff;

   always_comb begin
      if (cmd.front_wr) begin
         wdata = taken_ff;
      end else if (cmd.shift_wr) begin
         wdata = entry;
      end else begin
         wdata = entry | load_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff  <= mem[raddr];
         rvalid_ff <= valid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         front_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            valid_ff <= '0;
            front_ff <= '0;
         end else if (we) begin
            valid_ff[waddr] <= 1'b1;
            if (waddr == '0) begin
               front_ff <= wdata;
            end
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff   <= req_tdata[OP_W-1:0];
         pos_ff  <= req_tdata[OP_W +: POS_W];
         load_ff <= req_tdata[OP_W+POS_W +: BYTE_W];
         cur_ff  <= req_tdata[OP_W +: AW];
      end else if (cmd.shift_wr) begin
         cur_ff <= cur_ff - AW'(1);
      end
      if (cmd.take) begin
         taken_ff <= entry;
      end
      // a decoded byte always lands at the front, so both fields match
      if (cmd.rsp_load) begin
         rsp_sym_ff   <= front_ff;
         rsp_front_ff <= front_ff;
      end
   end

   assign status.op       = op_ff;
   assign status.pos_ok   = ({1'b0, pos_ff} < LEN_LIMIT);
   assign status.pos_zero = (pos_ff == '0);
   assign status.cur_one  = (cur_ff == AW'(1));
   assign status.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_front_ff, rsp_sym_ff};

   a_shift_not_front: assert property (@(posedge clock) disable iff (reset)
      cmd.shift_wr |-> cur_ff != '0)
      else $error("shift write aimed at the front entry");

   a_clear_zeroes_front: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> front_ff == '0 && valid_ff == '0)
      else $error("clear left list state behind");

   a_front_from_taken: assert property (@(posedge clock) disable iff (reset)
      cmd.front_wr |=> front_ff == $past(taken_ff))
      else $error("front entry differs from the decoded byte");

endmodule
